// File: rtl/src_pkg.sv
// Shared types and constants for the segment rectangle clipper.
// Used by src_pass and segment_rect_clipper_unit; depends on nothing.
`default_nettype none

package src_pkg;

    // Outcome of one clip pass for the sliding endpoint.
    typedef enum logic [1:0] {
        MODE_KEEP,
        MODE_FULL,
        MODE_FRAC
    } t_mode;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_X_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_MAX = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MAX = 2'd3;

    // Number of edge passes in the clip chain.
    localparam int unsigned NUM_PASSES = 8;

endpackage

`default_nettype wire

// File: rtl/src_pass.sv
// One clip pass: slides one endpoint toward the other against one edge.
// Pipelined over FRAC_BITS + 4 stages; depends on src_pkg.
`default_nettype none

module src_pass #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16,
    parameter int AXIS        = 0,
    parameter int MAX_EDGE    = 0,
    parameter int MOVE_END    = 0
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_en,
    input  wire signed [COORD_WIDTH-1:0] i_edge,
    input  wire                          i_vld,
    input  wire signed [COORD_WIDTH-1:0] i_ax,
    input  wire signed [COORD_WIDTH-1:0] i_ay,
    input  wire signed [COORD_WIDTH-1:0] i_bx,
    input  wire signed [COORD_WIDTH-1:0] i_by,
    output logic                         o_vld,
    output logic signed [COORD_WIDTH-1:0] o_ax,
    output logic signed [COORD_WIDTH-1:0] o_ay,
    output logic signed [COORD_WIDTH-1:0] o_bx,
    output logic signed [COORD_WIDTH-1:0] o_by
);

    localparam int W     = COORD_WIDTH;
    localparam int TW    = (FRAC_BITS > 0) ? FRAC_BITS : 1;
    localparam int PW    = TW + W + 1;
    localparam int DEPTH = FRAC_BITS + 4;
    localparam int S_MUL = FRAC_BITS + 2;
    localparam int S_FIN = FRAC_BITS + 3;
    localparam logic [PW-1:0] HALF = (FRAC_BITS > 0) ? (PW'(1) << (FRAC_BITS - 1)) : '0;

    typedef struct packed {
        logic                vld;
        logic signed [W-1:0] px;
        logic signed [W-1:0] py;
        logic signed [W-1:0] qx;
        logic signed [W-1:0] qy;
        logic signed [W:0]   num;
        logic signed [W:0]   den;
        logic signed [W:0]   d;
        logic                cond;
        src_pkg::t_mode      mode;
        logic [W+1:0]        rem;
        logic [W:0]          ud;
        logic [W:0]          ad;
        logic                dneg;
        logic [TW-1:0]       t;
        logic [W:0]          m;
    } t_stage;

    t_stage r_st [DEPTH];
    t_stage n_st [DEPTH];

    // Stage 0: pick the moving point, form the edge distance and deltas.
    always_comb begin
        logic signed [W-1:0] pa, po, qa, qo;
        n_st[0] = r_st[0];
        n_st[0].vld = i_vld;
        if (MOVE_END != 0) begin
            n_st[0].px = i_bx; n_st[0].py = i_by;
            n_st[0].qx = i_ax; n_st[0].qy = i_ay;
        end else begin
            n_st[0].px = i_ax; n_st[0].py = i_ay;
            n_st[0].qx = i_bx; n_st[0].qy = i_by;
        end
        pa = (AXIS != 0) ? n_st[0].py : n_st[0].px;
        po = (AXIS != 0) ? n_st[0].px : n_st[0].py;
        qa = (AXIS != 0) ? n_st[0].qy : n_st[0].qx;
        qo = (AXIS != 0) ? n_st[0].qx : n_st[0].qy;
        n_st[0].num  = {i_edge[W-1], i_edge} - {pa[W-1], pa};
        n_st[0].den  = {qa[W-1], qa} - {pa[W-1], pa};
        n_st[0].d    = {qo[W-1], qo} - {po[W-1], po};
        n_st[0].cond = (MAX_EDGE != 0) ? (pa > i_edge) : (pa < i_edge);
    end

    // Stage 1: magnitudes and the choice between keep, jump and slide.
    always_comb begin
        logic [W:0] un, ud;
        n_st[1] = r_st[0];
        un = r_st[0].num[W] ? (W+1)'(-r_st[0].num) : r_st[0].num;
        ud = r_st[0].den[W] ? (W+1)'(-r_st[0].den) : r_st[0].den;
        n_st[1].ad   = r_st[0].d[W] ? (W+1)'(-r_st[0].d) : r_st[0].d;
        n_st[1].dneg = r_st[0].d[W];
        n_st[1].ud   = ud;
        n_st[1].rem  = {1'b0, un};
        n_st[1].t    = '0;
        if (!r_st[0].cond || (r_st[0].den == '0) || (r_st[0].num[W] != r_st[0].den[W])) begin
            n_st[1].mode = src_pkg::MODE_KEEP;
        end else if (un >= ud) begin
            n_st[1].mode = src_pkg::MODE_FULL;
        end else begin
            n_st[1].mode = src_pkg::MODE_FRAC;
        end
    end

    // Division stages: one quotient bit of the slide fraction per stage.
    for (genvar k = 0; k < FRAC_BITS; k++) begin : g_div
        always_comb begin
            logic [W+1:0] r2;
            logic         qb;
            n_st[k+2] = r_st[k+1];
            r2 = {r_st[k+1].rem[W:0], 1'b0};
            qb = (r2 >= {1'b0, r_st[k+1].ud});
            n_st[k+2].rem = qb ? (r2 - {1'b0, r_st[k+1].ud}) : r2;
            n_st[k+2].t   = TW'({r_st[k+1].t, qb});
        end
    end

    // Multiply stage: scale the other-axis delta by the fraction, rounded.
    always_comb begin
        logic [PW-1:0] prod;
        n_st[S_MUL] = r_st[S_MUL-1];
        prod = (FRAC_BITS > 0) ? (PW'(r_st[S_MUL-1].t) * PW'(r_st[S_MUL-1].ad) + HALF) : '0;
        n_st[S_MUL].m = (W+1)'(prod >> FRAC_BITS);
    end

    // Final stage: apply the pass outcome to the moving point.
    always_comb begin
        logic signed [W:0] po_n;
        n_st[S_FIN] = r_st[S_MUL];
        if (AXIS != 0) begin
            po_n = {r_st[S_MUL].px[W-1], r_st[S_MUL].px};
        end else begin
            po_n = {r_st[S_MUL].py[W-1], r_st[S_MUL].py};
        end
        po_n = r_st[S_MUL].dneg ? (po_n - r_st[S_MUL].m) : (po_n + r_st[S_MUL].m);
        case (r_st[S_MUL].mode)
            src_pkg::MODE_FULL: begin
                n_st[S_FIN].px = r_st[S_MUL].qx;
                n_st[S_FIN].py = r_st[S_MUL].qy;
            end
            src_pkg::MODE_FRAC: begin
                if (AXIS != 0) begin
                    n_st[S_FIN].py = i_edge;
                    n_st[S_FIN].px = W'(po_n);
                end else begin
                    n_st[S_FIN].px = i_edge;
                    n_st[S_FIN].py = W'(po_n);
                end
            end
            default: begin
            end
        endcase
    end

    // Stage registers; only the valid bits are reset.
    always_ff @(posedge i_clk) begin
        for (int s = 0; s < DEPTH; s++) begin
            if (!i_rst_n) begin
                r_st[s].vld <= 1'b0;
            end else if (i_en) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    // Map the moving point back onto start or end.
    always_comb begin
        o_vld = r_st[S_FIN].vld;
        if (MOVE_END != 0) begin
            o_bx = r_st[S_FIN].px; o_by = r_st[S_FIN].py;
            o_ax = r_st[S_FIN].qx; o_ay = r_st[S_FIN].qy;
        end else begin
            o_ax = r_st[S_FIN].px; o_ay = r_st[S_FIN].py;
            o_bx = r_st[S_FIN].qx; o_by = r_st[S_FIN].qy;
        end
    end

endmodule

`default_nettype wire

// File: rtl/segment_rect_clipper_unit.sv
// Top level of the segment rectangle clipper: config registers, eight pass chain, output.
// Depends on src_pkg and src_pass.
//
//  Channel   Handshake                  Payload
//  in        i_in_valid / o_in_ready    i_start_x, i_start_y, i_end_x, i_end_y
//  out       o_out_valid / i_out_ready  o_visible, o_clip_start_x/y, o_clip_end_x/y
//  cfg       i_cfg_we (no wait)         i_cfg_idx, i_cfg_data
//
// One beat enters per cycle unless a finished beat waits at the output; each beat runs
// through the eight passes, each with a stage per quotient bit, and the output register.
// Reset clears all valid bits and the rectangle registers to zero.
// The whole pipeline holds while the output beat waits; nothing is dropped or repeated.
`default_nettype none

module segment_rect_clipper_unit #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire [src_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  wire [COORD_WIDTH-1:0]                 i_cfg_data,
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  wire signed [COORD_WIDTH-1:0]          i_start_x,
    input  wire signed [COORD_WIDTH-1:0]          i_start_y,
    input  wire signed [COORD_WIDTH-1:0]          i_end_x,
    input  wire signed [COORD_WIDTH-1:0]          i_end_y,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output logic                                  o_visible,
    output logic signed [COORD_WIDTH-1:0]         o_clip_start_x,
    output logic signed [COORD_WIDTH-1:0]         o_clip_start_y,
    output logic signed [COORD_WIDTH-1:0]         o_clip_end_x,
    output logic signed [COORD_WIDTH-1:0]         o_clip_end_y
);

    localparam int W  = COORD_WIDTH;
    localparam int NP = src_pkg::NUM_PASSES;

    logic signed [W-1:0] r_x_min, r_y_min, r_x_max, r_y_max;
    logic                r_vld;
    logic signed [W-1:0] r_ax, r_ay, r_bx, r_by;
    logic                r_vis;
    logic                en;

    logic                c_vld [NP+1];
    logic signed [W-1:0] c_ax  [NP+1];
    logic signed [W-1:0] c_ay  [NP+1];
    logic signed [W-1:0] c_bx  [NP+1];
    logic signed [W-1:0] c_by  [NP+1];

    // The pipeline advances unless a finished beat is stuck at the output.
    assign en         = !r_vld || i_out_ready;
    assign o_in_ready = en;

    // Rectangle registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min <= '0;
            r_y_min <= '0;
            r_x_max <= '0;
            r_y_max <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                src_pkg::CFG_X_MIN: r_x_min <= i_cfg_data;
                src_pkg::CFG_Y_MIN: r_y_min <= i_cfg_data;
                src_pkg::CFG_X_MAX: r_x_max <= i_cfg_data;
                src_pkg::CFG_Y_MAX: r_y_max <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign c_vld[0] = i_in_valid;
    assign c_ax[0]  = i_start_x;
    assign c_ay[0]  = i_start_y;
    assign c_bx[0]  = i_end_x;
    assign c_by[0]  = i_end_y;

    // Pass chain: left, right, bottom, top; start before end at each edge.
    for (genvar j = 0; j < NP; j++) begin : g_pass
        localparam int AX  = j / 4;
        localparam int MX  = (j / 2) % 2;
        localparam int MV  = j % 2;
        logic signed [W-1:0] edge_val;
        assign edge_val = (AX != 0) ? ((MX != 0) ? r_y_max : r_y_min)
                                    : ((MX != 0) ? r_x_max : r_x_min);
        src_pass #(
            .COORD_WIDTH (W),
            .FRAC_BITS   (FRAC_BITS),
            .AXIS        (AX),
            .MAX_EDGE    (MX),
            .MOVE_END    (MV)
        ) u_pass (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_edge  (edge_val),
            .i_vld   (c_vld[j]),
            .i_ax    (c_ax[j]),
            .i_ay    (c_ay[j]),
            .i_bx    (c_bx[j]),
            .i_by    (c_by[j]),
            .o_vld   (c_vld[j+1]),
            .o_ax    (c_ax[j+1]),
            .o_ay    (c_ay[j+1]),
            .o_bx    (c_bx[j+1]),
            .o_by    (c_by[j+1])
        );
    end

    // Output register: visibility test and zeroing of invisible segments.
    always_ff @(posedge i_clk) begin
        logic in_a, in_b;
        in_a = (c_ax[NP] >= r_x_min) && (c_ax[NP] <= r_x_max) &&
               (c_ay[NP] >= r_y_min) && (c_ay[NP] <= r_y_max);
        in_b = (c_bx[NP] >= r_x_min) && (c_bx[NP] <= r_x_max) &&
               (c_by[NP] >= r_y_min) && (c_by[NP] <= r_y_max);
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en) begin
            r_vld <= c_vld[NP];
            r_vis <= in_a || in_b;
            r_ax  <= (in_a || in_b) ? c_ax[NP] : '0;
            r_ay  <= (in_a || in_b) ? c_ay[NP] : '0;
            r_bx  <= (in_a || in_b) ? c_bx[NP] : '0;
            r_by  <= (in_a || in_b) ? c_by[NP] : '0;
        end
    end

    assign o_out_valid    = r_vld;
    assign o_visible      = r_vis;
    assign o_clip_start_x = r_ax;
    assign o_clip_start_y = r_ay;
    assign o_clip_end_x   = r_bx;
    assign o_clip_end_y   = r_by;

endmodule

`default_nettype wire
